/* src/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// shared widths, phase codes and controller/datapath interface structs for
// the plane span coalescer
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int SCREEN_ROWS = 64;
	localparam int ROW_W = $clog2(SCREEN_ROWS);
	localparam int COL_W = 9;
	localparam int EXT_W = 8;

	typedef enum logic [1:0] {
		PH_CT,
		PH_CB,
		PH_OT,
		PH_OB
	} phase_t;

	typedef struct packed {
		logic   load_in;
		logic   load_ctr;
		phase_t ld_phase;
		logic   step;
		logic   rd_en;
		logic   wr_en;
		phase_t phase;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0] en;
		logic       at_end;
		logic       can_issue;
	} dp_status_t;

endpackage

/* src/psc_ram.sv */
// ----------------------------------------------------------------------------
// psc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module psc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* src/psc_dp.sv */
// ----------------------------------------------------------------------------
// psc_dp
// datapath: input word latch, row range logic for the four scan phases,
// row counter, start-column ram, read stage and output register
// ----------------------------------------------------------------------------
module psc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psc_pkg::dp_cmd_t              cmd,
	output psc_pkg::dp_status_t           status,
	input  logic [psc_pkg::COL_W-1:0]     column,
	input  logic [psc_pkg::EXT_W-1:0]     prev_top,
	input  logic [psc_pkg::EXT_W-1:0]     prev_bottom,
	input  logic [psc_pkg::EXT_W-1:0]     cur_top,
	input  logic [psc_pkg::EXT_W-1:0]     cur_bottom,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [psc_pkg::ROW_W-1:0]     row,
	output logic [psc_pkg::COL_W-1:0]     span_start,
	output logic [psc_pkg::COL_W-1:0]     span_end,
	output logic                          last_span
);
	import psc_pkg::*;

	localparam int XW = EXT_W + 1;
	localparam logic [XW-1:0] ROW_LIM = XW'(SCREEN_ROWS);
	localparam logic [XW-1:0] ROW_MAX = XW'(SCREEN_ROWS - 1);
	localparam logic [XW-1:0] ONE = XW'(1);

	logic [COL_W-1:0] column_q;
	logic [EXT_W-1:0] prev_top_q, prev_bottom_q, cur_top_q, cur_bottom_q;
	logic [ROW_W-1:0] cnt_q;

	logic [XW-1:0] t1, b1, t2, b2;
	logic [XW-1:0] hi1, t1n, lo2, b1n, hi3, t2n, lo4;
	logic [XW-1:0] hi1c, hi2c, hi3c, hi4c;
	logic          act1, act2, act3, act4;
	logic [ROW_W-1:0] end_row, load_row;
	logic          asc;
	logic          last_now;
	logic [COL_W-1:0] end_val;

	logic             s1_v_q;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] end_s1;
	logic             last_s1;
	logic             adv;
	logic [COL_W-1:0] rd_data;

	logic             out_v_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] span_start_q, span_end_q;
	logic             last_span_q;

	// row ranges of the four phases
	assign t1 = {1'b0, prev_top_q};
	assign b1 = {1'b0, prev_bottom_q};
	assign t2 = {1'b0, cur_top_q};
	assign b2 = {1'b0, cur_bottom_q};

	assign act1 = (t1 < t2) && (t1 <= b1);
	assign hi1  = ((t2 - ONE) < b1) ? (t2 - ONE) : b1;
	assign t1n  = act1 ? (hi1 + ONE) : t1;

	assign act2 = (b1 > b2) && (b1 >= t1n);
	assign lo2  = ((b2 + ONE) > t1n) ? (b2 + ONE) : t1n;
	assign b1n  = act2 ? (lo2 - ONE) : b1;

	assign act3 = (t2 < t1n) && (t2 <= b2);
	assign hi3  = ((t1n - ONE) < b2) ? (t1n - ONE) : b2;
	assign t2n  = act3 ? (hi3 + ONE) : t2;

	assign act4 = (b2 > b1n) && (b2 >= t2n);
	assign lo4  = ((b1n + ONE) > t2n) ? (b1n + ONE) : t2n;

	// clip to the screen
	assign hi1c = (hi1 < ROW_LIM) ? hi1 : ROW_MAX;
	assign hi2c = (b1 < ROW_LIM) ? b1 : ROW_MAX;
	assign hi3c = (hi3 < ROW_LIM) ? hi3 : ROW_MAX;
	assign hi4c = (b2 < ROW_LIM) ? b2 : ROW_MAX;

	assign status.en[PH_CT] = act1 && (t1 < ROW_LIM);
	assign status.en[PH_CB] = act2 && (lo2 < ROW_LIM);
	assign status.en[PH_OT] = act3 && (t2 < ROW_LIM);
	assign status.en[PH_OB] = act4 && (lo4 < ROW_LIM);

	always_comb begin
		case (cmd.ld_phase)
			PH_CT:   load_row = t1[ROW_W-1:0];
			PH_CB:   load_row = hi2c[ROW_W-1:0];
			PH_OT:   load_row = t2[ROW_W-1:0];
			PH_OB:   load_row = hi4c[ROW_W-1:0];
			default: load_row = t1[ROW_W-1:0];
		endcase
		case (cmd.phase)
			PH_CT: begin
				end_row   = hi1c[ROW_W-1:0];
				asc       = 1'b1;
			end
			PH_CB: begin
				end_row   = lo2[ROW_W-1:0];
				asc       = 1'b0;
			end
			PH_OT: begin
				end_row   = hi3c[ROW_W-1:0];
				asc       = 1'b1;
			end
			PH_OB: begin
				end_row   = lo4[ROW_W-1:0];
				asc       = 1'b0;
			end
			default: begin
				end_row   = hi1c[ROW_W-1:0];
				asc       = 1'b1;
			end
		endcase
	end

	assign status.at_end = (cnt_q == end_row);
	assign last_now = status.at_end &&
		((cmd.phase == PH_CB) || ((cmd.phase == PH_CT) && !status.en[PH_CB]));
	assign end_val = column_q - COL_W'(1);

	// read stage and output register
	assign adv = s1_v_q && (!out_v_q || !out_stall);
	assign status.can_issue = !s1_v_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				s1_v_q <= 1'b1;
			end else if (adv) begin
				s1_v_q <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			column_q      <= column;
			prev_top_q    <= prev_top;
			prev_bottom_q <= prev_bottom;
			cur_top_q     <= cur_top;
			cur_bottom_q  <= cur_bottom;
		end
		if (cmd.load_ctr) begin
			cnt_q <= load_row;
		end else if (cmd.step) begin
			cnt_q <= asc ? (cnt_q + ROW_W'(1)) : (cnt_q - ROW_W'(1));
		end
		if (cmd.rd_en) begin
			row_s1  <= cnt_q;
			end_s1  <= end_val;
			last_s1 <= last_now;
		end
		if (adv) begin
			row_q        <= row_s1;
			span_start_q <= rd_data;
			span_end_q   <= end_s1;
			last_span_q  <= last_s1;
		end
	end

	psc_ram #(
		.WIDTH (COL_W),
		.DEPTH (SCREEN_ROWS)
	) u_start_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (cnt_q),
		.wr_data (column_q),
		.rd_en   (cmd.rd_en),
		.rd_addr (cnt_q),
		.rd_data (rd_data)
	);

	assign out_valid  = out_v_q;
	assign row        = row_q;
	assign span_start = span_start_q;
	assign span_end   = span_end_q;
	assign last_span  = last_span_q;

endmodule

/* src/psc_ctrl.sv */
// ----------------------------------------------------------------------------
// psc_ctrl
// controller: takes one input word, then walks the close-top, close-bottom,
// open-top and open-bottom phases, skipping the empty ones
// ----------------------------------------------------------------------------
module psc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  psc_pkg::dp_status_t status,
	output psc_pkg::dp_cmd_t    cmd
);
	import psc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_CT,
		S_CB,
		S_OT,
		S_OB
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] mask;
	logic       done;
	logic       found;
	phase_t     nxt_ph;

	function automatic state_t ph_state(input phase_t p);
		case (p)
			PH_CT:   ph_state = S_CT;
			PH_CB:   ph_state = S_CB;
			PH_OT:   ph_state = S_OT;
			PH_OB:   ph_state = S_OB;
			default: ph_state = S_CT;
		endcase
	endfunction

	// lowest enabled phase still ahead
	always_comb begin
		found  = |mask;
		nxt_ph = PH_OB;
		if (mask[PH_OT]) begin
			nxt_ph = PH_OT;
		end
		if (mask[PH_CB]) begin
			nxt_ph = PH_CB;
		end
		if (mask[PH_CT]) begin
			nxt_ph = PH_CT;
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.phase    = PH_CT;
		cmd.ld_phase = nxt_ph;
		state_d      = state_q;
		mask         = 4'b0000;
		done         = 1'b0;
		in_stall     = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_START;
				end
			end
			S_START: begin
				mask = status.en;
				done = 1'b1;
			end
			S_CT: begin
				cmd.phase  = PH_CT;
				mask       = status.en & 4'b1110;
				cmd.rd_en  = status.can_issue;
				done       = status.can_issue;
			end
			S_CB: begin
				cmd.phase  = PH_CB;
				mask       = status.en & 4'b1100;
				cmd.rd_en  = status.can_issue;
				done       = status.can_issue;
			end
			S_OT: begin
				cmd.phase  = PH_OT;
				mask       = status.en & 4'b1000;
				cmd.wr_en  = 1'b1;
				done       = 1'b1;
			end
			S_OB: begin
				cmd.phase  = PH_OB;
				cmd.wr_en  = 1'b1;
				done       = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (done) begin
			if ((state_q == S_START) || status.at_end) begin
				if (found) begin
					cmd.load_ctr = 1'b1;
					state_d      = ph_state(nxt_ph);
				end else begin
					state_d = S_IDLE;
				end
			end else begin
				cmd.step = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/plane_span_coalescer.sv */
// ----------------------------------------------------------------------------
// plane_span_coalescer
// turns column extents into closed row spans
// ----------------------------------------------------------------------------
// One column word is taken at a time. After the word is accepted the block
// first sets up the row ranges, then handles every on-screen row whose run
// closes (each reads that row's start column from the start-column ram,
// whose single read port sets the pace) and every on-screen row that opens
// (single write port); rows off the screen are skipped. The input stays
// stalled for the whole word, also while the output is stalled with its read
// stage full. Spans come out one per cycle while the output is not stalled,
// closing rows from the top downward, then from the bottom upward, with
// last_span set on the final span of a column. A column that closes nothing
// gives no spans. Start columns of rows never opened read as undefined.
module plane_span_coalescer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [psc_pkg::COL_W-1:0] column,
	input  logic [psc_pkg::EXT_W-1:0] prev_top,
	input  logic [psc_pkg::EXT_W-1:0] prev_bottom,
	input  logic [psc_pkg::EXT_W-1:0] cur_top,
	input  logic [psc_pkg::EXT_W-1:0] cur_bottom,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [psc_pkg::ROW_W-1:0] row,
	output logic [psc_pkg::COL_W-1:0] span_start,
	output logic [psc_pkg::COL_W-1:0] span_end,
	output logic                      last_span
);
	import psc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	psc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	psc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.column      (column),
		.prev_top    (prev_top),
		.prev_bottom (prev_bottom),
		.cur_top     (cur_top),
		.cur_bottom  (cur_bottom),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.row         (row),
		.span_start  (span_start),
		.span_end    (span_end),
		.last_span   (last_span)
	);

endmodule

/* src/psc_checker.sv */
// ----------------------------------------------------------------------------
// psc_checker
// port-level checks for the plane span coalescer
// ----------------------------------------------------------------------------
module psc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [psc_pkg::ROW_W-1:0] row,
	input logic [psc_pkg::COL_W-1:0] span_start,
	input logic [psc_pkg::COL_W-1:0] span_end,
	input logic                      last_span
);
	import psc_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row) && $stable(span_start)
			&& $stable(span_end) && $stable(last_span))
		else $error("stalled output word changed");

	// one word at a time: input closes right after an accept
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// reset leaves the block idle and empty
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("block not idle in reset");

endmodule

bind plane_span_coalescer psc_checker u_psc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.row        (row),
	.span_start (span_start),
	.span_end   (span_end),
	.last_span  (last_span)
);
